>>> rtl/core/sfbe_pkg.sv
// sfbe_pkg: shared types and constants for the surface fill and blit engine
// no dependencies
`timescale 1ns / 1ps

package sfbe_pkg;

   localparam logic [15:0] BACK_ID = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_CREATE = 2'd0,
      KIND_FILL   = 2'd1,
      KIND_BLIT   = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_BAD = 2'd1,
      ST_BIG = 2'd2,
      ST_OUT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CREATE,
      CMD_CLIP,
      CMD_ROWS,
      CMD_STEP,
      CMD_RDADDR
   } cmd_type;

   typedef struct packed {
      logic       ok_ids;
      logic       rd_in;
      logic       empty;
      logic       last;
      status_type chk;
   } stat_type;

endpackage

>>> rtl/core/surface_fill_blit_engine.sv
// surface_fill_blit_engine: top level of the surface fill and blit engine
// depends on sfbe_pkg, sfbe_ctrl, sfbe_datapath
`timescale 1ns / 1ps

// One command is taken at a time and gives one response, and the input stays
// closed until that response is in the output register. A create or any command
// rejected by its checks goes from the check state straight to the response; a
// read passes through the read states S_RDA and S_RDB first, and a fill or blit
// through clip and row setup, then writes one pixel per cycle of the clipped
// rectangle through the single write port of the pixel memory. A stalled response
// holds the engine only while the output register is still full.
module surface_fill_blit_engine
   import sfbe_pkg::*;
#(
   parameter int SURFACES      = 8,
   parameter int SURFACE_WORDS = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // kind, dest_id, src_id, dest_x, dest_y, src_x, src_y, width, height, colour, zero pad
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, pixel, zero pad
   output logic [39:0]  rsp_tdata
);

   cmd_type     cmd;
   stat_type    stat;
   status_type  cst;
   logic        rsp_load, psel;
   logic [31:0] rd_data;
   logic        vld_ff;
   logic [33:0] data_ff;
   kind_type    cur_kind;
   logic        free;

   assign free = !vld_ff || rsp_tready;

   sfbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .kind       (cur_kind),
      .stat       (stat),
      .cmd        (cmd),
      .rsp_load   (rsp_load),
      .rsp_status (cst),
      .rsp_pix_sel(psel),
      .rsp_free   (free)
   );

   sfbe_datapath #(
      .SURFACES      (SURFACES),
      .SURFACE_WORDS (SURFACE_WORDS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .kind     (kind_type'(req_tdata[1:0])),
      .cur_kind (cur_kind),
      .dest_id  (req_tdata[17:2]),
      .src_id   (req_tdata[33:18]),
      .dest_x   (req_tdata[49:34]),
      .dest_y   (req_tdata[65:50]),
      .src_x    (req_tdata[81:66]),
      .src_y    (req_tdata[97:82]),
      .width    (req_tdata[113:98]),
      .height   (req_tdata[129:114]),
      .colour   (req_tdata[161:130]),
      .rd_data  (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (rsp_load) vld_ff <= 1'b1;
      else if (rsp_tready) vld_ff <= 1'b0;
      if (rsp_load) data_ff <= {(psel ? rd_data : 32'd0), cst};
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {6'd0, data_ff};

endmodule

>>> rtl/core/sfbe_ctrl.sv
// sfbe_ctrl: command sequencer for the surface fill and blit engine
// depends on sfbe_pkg
`timescale 1ns / 1ps

module sfbe_ctrl
   import sfbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  kind_type   kind,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       rsp_load,
   output status_type rsp_status,
   output logic       rsp_pix_sel,
   input  logic       rsp_free
);

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_CLIP, S_ROWS, S_RUN, S_RDA, S_RDB, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   status_type st_ff, st_in;
   logic       psel_ff, psel_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_status = st_ff;
   assign rsp_pix_sel = psel_ff;
   assign rsp_load = (state_ff == S_DONE) && rsp_free;

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      psel_in  = psel_ff;
      cmd      = CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            psel_in = 1'b0;
            if (req_tvalid) begin
               cmd      = CMD_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            st_in = stat.chk;
            if (kind == KIND_CREATE) begin
               cmd      = CMD_CREATE;
               state_in = S_DONE;
            end else if (!stat.ok_ids || stat.chk != ST_OK) begin
               state_in = S_DONE;
            end else if (kind == KIND_READ) begin
               cmd      = CMD_RDADDR;
               state_in = S_RDA;
            end else begin
               state_in = S_CLIP;
            end
         end
         S_CLIP: begin
            cmd      = CMD_CLIP;
            state_in = S_ROWS;
         end
         S_ROWS: begin
            cmd      = CMD_ROWS;
            state_in = stat.empty ? S_DONE : S_RUN;
         end
         S_RUN: begin
            cmd = CMD_STEP;
            if (stat.last) state_in = S_DONE;
         end
         S_RDA: state_in = S_RDB;
         S_RDB: begin
            psel_in  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= ST_OK;
         psel_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
         psel_ff  <= psel_in;
      end
   end

endmodule

>>> rtl/core/sfbe_datapath.sv
// sfbe_datapath: surface table, clipping, address walk and pixel memory
// depends on sfbe_pkg
`timescale 1ns / 1ps

module sfbe_datapath
   import sfbe_pkg::*;
#(
   parameter int SURFACES      = 8,
   parameter int SURFACE_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  kind_type    kind,
   output kind_type    cur_kind,
   input  logic [15:0] dest_id,
   input  logic [15:0] src_id,
   input  logic [15:0] dest_x,
   input  logic [15:0] dest_y,
   input  logic [15:0] src_x,
   input  logic [15:0] src_y,
   input  logic [15:0] width,
   input  logic [15:0] height,
   input  logic [31:0] colour,
   output logic [31:0] rd_data
);

   localparam int IW = (SURFACES > 1) ? $clog2(SURFACES) : 1;
   localparam int OW = $clog2(SURFACE_WORDS);
   localparam int SW = OW + 1;
   localparam int AW = IW + OW;
   localparam int DEPTH = SURFACES << OW;

   logic [SURFACES-1:0] live_ff;
   logic [SW-1:0]       sw_ff [SURFACES];
   logic [SW-1:0]       sh_ff [SURFACES];
   logic [31:0]         mem [DEPTH];

   logic [15:0] did_ff, sid_ff, dx_ff, dy_ff, sx_ff, sy_ff, w_ff, h_ff;
   logic [31:0] col_ff;
   logic        blit_ff;
   kind_type    kind_ff;

   logic [IW-1:0] didx, sidx;
   logic          dback, sback, dok, sok;
   logic [SW-1:0] dw, dh, sw, sh;
   logic [31:0]   area;

   assign cur_kind = kind_ff;
   assign didx  = did_ff[IW-1:0];
   assign sidx  = sid_ff[IW-1:0];
   assign dback = (did_ff == BACK_ID);
   assign sback = (sid_ff == BACK_ID);
   assign dok   = dback || ((32'(did_ff) < 32'(SURFACES)) && live_ff[didx]);
   assign sok   = sback || ((32'(sid_ff) < 32'(SURFACES)) && live_ff[sidx]);
   assign dw    = dback ? '0 : sw_ff[didx];
   assign dh    = dback ? '0 : sh_ff[didx];
   assign sw    = sback ? '0 : sw_ff[sidx];
   assign sh    = sback ? '0 : sh_ff[sidx];
   assign area  = w_ff * h_ff;

   // clipped width/height, row walk
   logic [SW-1:0] cw_ff, ch_ff, pw_d_ff, pw_s_ff;
   logic          skip_ff;
   logic [SW-1:0] col_cnt_ff, row_cnt_ff;
   logic [AW-1:0] drow_ff, srow_ff, dptr_ff, sptr_ff;
   logic [AW-1:0] rd_addr, rd_pos;
   logic [31:0]   rdq_ff, wr_data;
   logic          wr_en;
   logic [16:0]   dxw, dyh;
   logic [16:0]   cw1, ch1;

   assign dxw = 17'(dx_ff) + 17'(w_ff);
   assign dyh = 17'(dy_ff) + 17'(h_ff);

   always_comb begin
      cw1 = 17'(w_ff);
      if (dxw > 17'(dw)) cw1 = 17'(dw) - 17'(dx_ff);
      if (blit_ff && (17'(sx_ff) + cw1 > 17'(sw))) cw1 = 17'(sw) - 17'(sx_ff);
      ch1 = 17'(h_ff);
      if (dyh > 17'(dh)) ch1 = 17'(dh) - 17'(dy_ff);
      if (blit_ff && (17'(sy_ff) + ch1 > 17'(sh))) ch1 = 17'(sh) - 17'(sy_ff);
   end

   logic ovr;
   assign ovr = (17'(dx_ff) > 17'(dw)) || (17'(dy_ff) > 17'(dh)) ||
                (blit_ff && ((17'(sx_ff) > 17'(sw)) || (17'(sy_ff) > 17'(sh))));

   always_comb begin
      stat.ok_ids = dok && (!blit_ff || sok);
      stat.rd_in  = (17'(dx_ff) < 17'(dw)) && (17'(dy_ff) < 17'(dh));
      stat.empty  = skip_ff || (cw_ff == '0) || (ch_ff == '0);
      stat.last   = (col_cnt_ff == cw_ff - SW'(1)) && (row_cnt_ff == ch_ff - SW'(1));
      stat.chk    = ST_OK;
      unique case (kind_ff)
         KIND_CREATE: begin
            if (dback || (32'(did_ff) >= 32'(SURFACES))) stat.chk = ST_BAD;
            else if ((32'(w_ff) > 32'(SURFACE_WORDS)) || (32'(h_ff) > 32'(SURFACE_WORDS)) ||
                     (area > 32'(SURFACE_WORDS))) stat.chk = ST_BIG;
         end
         KIND_READ: begin
            if (!stat.ok_ids) stat.chk = ST_BAD;
            else if (!stat.rd_in) stat.chk = ST_OUT;
         end
         KIND_FILL, KIND_BLIT: begin
            if (!stat.ok_ids) stat.chk = ST_BAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
         for (int i = 0; i < SURFACES; i++) begin
            sw_ff[i] <= '0;
            sh_ff[i] <= '0;
         end
      end else if (cmd == CMD_CREATE && stat.chk == ST_OK) begin
         live_ff[didx] <= 1'b1;
         sw_ff[didx]   <= SW'(w_ff);
         sh_ff[didx]   <= SW'(h_ff);
      end
   end

   assign rd_pos = AW'({didx, OW'(0)}) + AW'(32'(dy_ff) * 32'(dw)) + AW'(dx_ff);

   // read address runs one pixel ahead of the write address
   always_comb begin
      rd_addr = sptr_ff;
      unique case (cmd)
         CMD_ROWS:   rd_addr = srow_ff;
         CMD_STEP:   rd_addr = (col_cnt_ff == cw_ff - SW'(1)) ? srow_ff + AW'(pw_s_ff)
                                                              : sptr_ff + AW'(1);
         CMD_RDADDR: rd_addr = rd_pos;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      sptr_ff <= rd_addr;
      unique case (cmd)
         CMD_LOAD: begin
            did_ff  <= dest_id;
            sid_ff  <= src_id;
            dx_ff   <= dest_x;
            dy_ff   <= dest_y;
            sx_ff   <= src_x;
            sy_ff   <= src_y;
            w_ff    <= width;
            h_ff    <= height;
            col_ff  <= colour;
            kind_ff <= kind;
            blit_ff <= (kind == KIND_BLIT);
         end
         CMD_CLIP: begin
            skip_ff <= ovr;
            cw_ff   <= SW'(cw1);
            ch_ff   <= SW'(ch1);
            pw_d_ff <= dw;
            pw_s_ff <= sw;
            drow_ff <= AW'({didx, OW'(0)}) + AW'(32'(dy_ff) * 32'(dw)) + AW'(dx_ff);
            srow_ff <= AW'({sidx, OW'(0)}) + AW'(32'(sy_ff) * 32'(sw)) + AW'(sx_ff);
         end
         CMD_ROWS: begin
            dptr_ff    <= drow_ff;
            col_cnt_ff <= '0;
            row_cnt_ff <= '0;
         end
         CMD_STEP: begin
            if (col_cnt_ff == cw_ff - SW'(1)) begin
               col_cnt_ff <= '0;
               row_cnt_ff <= row_cnt_ff + SW'(1);
               drow_ff    <= drow_ff + AW'(pw_d_ff);
               srow_ff    <= srow_ff + AW'(pw_s_ff);
               dptr_ff    <= drow_ff + AW'(pw_d_ff);
            end else begin
               col_cnt_ff <= col_cnt_ff + SW'(1);
               dptr_ff    <= dptr_ff + AW'(1);
            end
         end
         default: ;
      endcase
   end

   // one pixel per cycle; a read of the word written in the same cycle takes the new value
   assign wr_en   = (cmd == CMD_STEP);
   assign wr_data = blit_ff ? rdq_ff : col_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[dptr_ff] <= wr_data;
      rdq_ff <= (wr_en && (dptr_ff == rd_addr)) ? wr_data : mem[rd_addr];
   end

   assign rd_data = rdq_ff;

endmodule

>>> bench/tb_surface_fill_blit_engine.sv
// tb_surface_fill_blit_engine: self-checking bench for the surface fill and blit engine
// depends on sfbe_pkg and surface_fill_blit_engine; predicts each response and compares
`timescale 1ns / 1ps

module tb_surface_fill_blit_engine
   import sfbe_pkg::*;
();

   localparam int NSURF    = 8;
   localparam int SLOT     = 4096;
   localparam int WDOG_MAX = 40000;

   typedef struct {
      kind_type    kind;
      logic [15:0] dest_id, src_id, dest_x, dest_y, src_x, src_y, width, height;
      logic [31:0] colour;
   } cmd_item_type;

   typedef struct {
      status_type  status;
      logic [31:0] pixel;
   } answer_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;

   cmd_item_type cmd_pending[$];
   answer_type   answer_q[$];
   cmd_item_type cmd_live;
   bit          failed = 1'b0;
   int          sent = 0;
   int          cycles = 0;
   int          quiet = 0;

   // bench copy of the surface table and pixel memory
   bit          s_live[NSURF];
   int          s_w[NSURF];
   int          s_h[NSURF];
   logic [31:0] pix_mem[NSURF*SLOT];

   surface_fill_blit_engine u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [167:0] pack_cmd(cmd_item_type c);
      return {6'd0, c.colour, c.height, c.width, c.src_y, c.src_x, c.dest_y, c.dest_x,
              c.src_id, c.dest_id, c.kind};
   endfunction

   function automatic bit find_surface(int id, output int w, output int h,
                                       output int base);
      w = 0; h = 0; base = 0;
      if (id == int'(BACK_ID)) return 1'b1;
      if (id >= NSURF || !s_live[id]) return 1'b0;
      w = s_w[id]; h = s_h[id]; base = id * SLOT;
      return 1'b1;
   endfunction

   task automatic predict_answer(cmd_item_type c);
      answer_type a;
      int dw, dh, db, sw, sh, sb, x, y, sx, sy, w, h, did, sid;
      a.status = ST_OK;
      a.pixel  = '0;
      x = int'(c.dest_x); y = int'(c.dest_y); sx = int'(c.src_x); sy = int'(c.src_y);
      w = int'(c.width); h = int'(c.height);
      did = int'(c.dest_id); sid = int'(c.src_id);
      case (c.kind)
         KIND_CREATE: begin
            if (did == int'(BACK_ID) || did >= NSURF) a.status = ST_BAD;
            else if (w > SLOT || h > SLOT || w * h > SLOT) a.status = ST_BIG;
            else begin
               s_live[did] = 1'b1; s_w[did] = w; s_h[did] = h;
            end
         end
         KIND_FILL: begin
            if (!find_surface(did, dw, dh, db)) a.status = ST_BAD;
            else if (x <= dw && y <= dh) begin
               if (x + w > dw) w = dw - x;
               if (y + h > dh) h = dh - y;
               for (int i = 0; i < h; i++)
                  for (int j = 0; j < w; j++)
                     pix_mem[db + (y + i) * dw + x + j] = c.colour;
            end
         end
         KIND_BLIT: begin
            if (!find_surface(sid, sw, sh, sb)) a.status = ST_BAD;
            else if (!find_surface(did, dw, dh, db)) a.status = ST_BAD;
            else if (x <= dw && y <= dh && sx <= sw && sy <= sh) begin
               if (x + w > dw) w = dw - x;
               if (sx + w > sw) w = sw - sx;
               if (y + h > dh) h = dh - y;
               if (sy + h > sh) h = sh - sy;
               for (int i = 0; i < h; i++)
                  for (int j = 0; j < w; j++)
                     pix_mem[db + (y + i) * dw + x + j] =
                        pix_mem[sb + (sy + i) * sw + sx + j];
            end
         end
         default: begin
            if (!find_surface(did, dw, dh, db)) a.status = ST_BAD;
            else if (x >= dw || y >= dh) a.status = ST_OUT;
            else a.pixel = pix_mem[db + y * dw + x];
         end
      endcase
      answer_q.push_back(a);
   endtask

   function automatic cmd_item_type make_cmd(kind_type k, int did, int sid, int dx, int dy,
                                             int sx, int sy, int w, int h,
                                             logic [31:0] col);
      cmd_item_type c;
      c.kind = k; c.dest_id = 16'(did); c.src_id = 16'(sid);
      c.dest_x = 16'(dx); c.dest_y = 16'(dy); c.src_x = 16'(sx); c.src_y = 16'(sy);
      c.width = 16'(w); c.height = 16'(h); c.colour = col;
      return c;
   endfunction

   function automatic int pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 85) return $urandom_range(NSURF - 1);
      if (r < 92) return int'(BACK_ID);
      return $urandom_range(16'hFFFF);
   endfunction

   function automatic int pick_coord();
      if ($urandom_range(99) < 6) return $urandom_range(16'hFFFF);
      return $urandom_range(70);
   endfunction

   function automatic cmd_item_type random_cmd();
      cmd_item_type c;
      int w, h;
      c = make_cmd(kind_type'($urandom_range(3)), pick_id(), pick_id(), pick_coord(),
                   pick_coord(), pick_coord(), pick_coord(), $urandom_range(24),
                   $urandom_range(24), $urandom());
      if (c.kind == KIND_CREATE) begin
         w = $urandom_range(1, 64);
         h = $urandom_range(1, SLOT / w);
         c.width = 16'(w); c.height = 16'(h);
         if ($urandom_range(99) < 15) begin
            c.width = 16'($urandom_range(16'hFFFF)); c.height = 16'($urandom_range(16'hFFFF));
         end
      end else if ($urandom_range(99) < 6) begin
         c.width = 16'($urandom_range(16'hFFFF)); c.height = 16'($urandom_range(16'hFFFF));
      end
      return c;
   endfunction

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_answer(cmd_live);
            sent <= sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_pending.size() > 0 &&
                ((sent > 60 && sent < 95) || $urandom_range(99) >= 6)) begin
               cmd_live   = cmd_pending.pop_front();
               req_tdata  <= pack_cmd(cmd_live);
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and response stall
   always @(posedge clock) begin
      answer_type exp_a;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (cycles > 30000 && cycles < 60000) || $urandom_range(99) >= 6;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
         else quiet <= quiet + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               $error("response transfer with no command outstanding");
               failed = 1'b1;
            end else begin
               exp_a = answer_q.pop_front();
               if (rsp_tdata[1:0] !== exp_a.status) begin
                  $error("status: expected %0d, got %0d", exp_a.status, rsp_tdata[1:0]);
                  failed = 1'b1;
               end
               if (rsp_tdata[33:2] !== exp_a.pixel) begin
                  $error("pixel: expected %h, got %h", exp_a.pixel, rsp_tdata[33:2]);
                  failed = 1'b1;
               end
            end
         end
         if (quiet >= WDOG_MAX) begin
            $display("FAIL surface_fill_blit_engine");
            $finish;
         end
      end
   end

   initial begin
      // every slot word gets written first so no later read sees an unwritten word
      for (int s = 0; s < NSURF; s++) begin
         cmd_pending.push_back(make_cmd(KIND_CREATE, s, 0, 0, 0, 0, 0, 64, 64, 0));
         cmd_pending.push_back(make_cmd(KIND_FILL, s, 0, 0, 0, 0, 0, 64, 64,
                                        32'hA5000000 | s));
      end
      cmd_pending.push_back(make_cmd(KIND_CREATE, BACK_ID, 0, 0, 0, 0, 0, 4, 4, 0));
      cmd_pending.push_back(make_cmd(KIND_CREATE, NSURF, 0, 0, 0, 0, 0, 4, 4, 0));
      cmd_pending.push_back(make_cmd(KIND_CREATE, 1, 0, 0, 0, 0, 0, 4097, 1, 0));
      cmd_pending.push_back(make_cmd(KIND_CREATE, 1, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0));
      cmd_pending.push_back(make_cmd(KIND_CREATE, 1, 0, 0, 0, 0, 0, 64, 65, 0));
      cmd_pending.push_back(make_cmd(KIND_CREATE, 2, 0, 0, 0, 0, 0, 4096, 1, 0));
      cmd_pending.push_back(make_cmd(KIND_CREATE, 3, 0, 0, 0, 0, 0, 0, 0, 0));
      cmd_pending.push_back(make_cmd(KIND_READ, BACK_ID, 0, 0, 0, 0, 0, 0, 0, 0));
      cmd_pending.push_back(make_cmd(KIND_READ, 16'hFFFE, 0, 0, 0, 0, 0, 0, 0, 0));
      cmd_pending.push_back(make_cmd(KIND_READ, 0, 0, 64, 0, 0, 0, 0, 0, 0));
      cmd_pending.push_back(make_cmd(KIND_FILL, BACK_ID, 0, 0, 0, 0, 0, 5, 5, 32'hFFFFFFFF));
      cmd_pending.push_back(make_cmd(KIND_FILL, 0, 0, 60, 62, 0, 0, 16'hFFFF, 16'hFFFF,
                                     32'hFFFFFFFF));
      cmd_pending.push_back(make_cmd(KIND_FILL, 0, 0, 64, 0, 0, 0, 5, 5, 32'h0));
      cmd_pending.push_back(make_cmd(KIND_FILL, 0, 0, 65, 0, 0, 0, 5, 5, 32'h0));
      cmd_pending.push_back(make_cmd(KIND_BLIT, 0, 16'h1234, 0, 0, 0, 0, 4, 4, 0));
      cmd_pending.push_back(make_cmd(KIND_BLIT, 0, 0, 2, 2, 0, 0, 8, 8, 0));
      cmd_pending.push_back(make_cmd(KIND_BLIT, 4, 0, 0, 0, 60, 62, 64, 64, 0));
      cmd_pending.push_back(make_cmd(KIND_BLIT, BACK_ID, 0, 0, 0, 0, 0, 4, 4, 0));
      cmd_pending.push_back(make_cmd(KIND_READ, 0, 0, 63, 63, 0, 0, 0, 0, 0));
      cmd_pending.push_back(make_cmd(KIND_READ, 0, 0, 3, 3, 0, 0, 0, 0, 0));
      cmd_pending.push_back(make_cmd(KIND_CREATE, 3, 0, 0, 0, 0, 0, 32, 32, 0));
      for (int n = 0; n < 102; n++) cmd_pending.push_back(random_cmd());

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (cmd_pending.size() > 0 || req_tvalid || answer_q.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed) $display("PASS surface_fill_blit_engine");
      else $display("FAIL surface_fill_blit_engine");
      $finish;
   end

endmodule
